/* rtl/resource_range_claim_table_defines.svh */
// Assertion macros for the resource range claim table.
// Used by the top level only; depends on nothing else.
`ifndef RESOURCE_RANGE_CLAIM_TABLE_DEFINES_SVH
`define RESOURCE_RANGE_CLAIM_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RRCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RRCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rrct_pkg.sv */
// Shared types and constants for the resource range claim table.
// No dependencies; imported by rrct_cmp and resource_range_claim_table.
`default_nettype none

package rrct_pkg;

    // Default sizes of the table and of the owner space.
    localparam int unsigned TABLE_DEPTH_DEF = 64;
    localparam int unsigned OWNER_COUNT_DEF = 32;

    // Field widths fixed by the interface.
    localparam int unsigned ACT_W       = 2;
    localparam int unsigned OWNER_ID_W  = 5;
    localparam int unsigned TYPE_W      = 3;
    localparam int unsigned VAL_W       = 64;
    localparam int unsigned NTH_W       = 6;
    localparam int unsigned MC_W        = 7;
    localparam int unsigned IN_TDATA_W  = 144;
    localparam int unsigned IN_TUSER_W  = 3;
    localparam int unsigned OUT_TDATA_W = 144;
    localparam int unsigned OUT_TUSER_W = 1;

    // Request kinds.
    typedef enum logic [ACT_W-1:0] {
        ACT_CLAIM   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_COUNT   = 2'd2,
        ACT_GET     = 2'd3
    } t_action;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_MOVE,
        ST_APPEND,
        ST_DONE
    } t_state;

    // One stored range; the inclusive end is kept so the scan needs no adder.
    typedef struct packed {
        logic [TYPE_W-1:0] rtype;
        logic [VAL_W-1:0]  start;
        logic [VAL_W-1:0]  size;
        logic [VAL_W-1:0]  last;
    } t_range;

    // Result of comparing one stored entry against the request.
    typedef struct packed {
        logic overlap;
        logic owner_eq;
    } t_cmp_res;

endpackage

`default_nettype wire

/* rtl/rrct_cmp.sv */
// Shared compare unit: range overlap and owner match of one entry.
// Depends on rrct_pkg.
`default_nettype none

module rrct_cmp #(
    parameter int unsigned OW = 5
) (
    input  wire logic [rrct_pkg::TYPE_W-1:0] i_irq_type,
    input  wire rrct_pkg::t_range            i_entry,
    input  wire logic [OW-1:0]               i_entry_owner,
    input  wire rrct_pkg::t_range            i_req,
    input  wire logic [OW-1:0]               i_req_owner,
    output rrct_pkg::t_cmp_res               o_res
);
    import rrct_pkg::*;

    logic w_type_eq;
    logic w_is_irq;
    logic w_zero;
    logic w_span_hit;

    // Interrupt lines match on start alone; other types use inclusive spans.
    always_comb begin
        w_type_eq  = (i_entry.rtype == i_req.rtype);
        w_is_irq   = (i_entry.rtype == i_irq_type);
        w_zero     = (i_entry.size == '0) || (i_req.size == '0);
        w_span_hit = (i_entry.start <= i_req.last) && (i_req.start <= i_entry.last);
        if (!w_type_eq) begin
            o_res.overlap = 1'b0;
        end else if (w_is_irq) begin
            o_res.overlap = (i_entry.start == i_req.start);
        end else begin
            o_res.overlap = !w_zero && w_span_hit;
        end
        o_res.owner_eq = (i_entry_owner == i_req_owner);
    end

endmodule

`default_nettype wire

/* rtl/resource_range_claim_table.sv */
// Channel     Dir  Fields (lowest bit first)
// s_axis      in   tuser: action, has_owner; tdata: owner_id, res_type, res_start,
//                  res_size, nth_index
// m_axis      out  tuser: ok; tdata: match_count, out_type, out_start, out_size
// cfg         in   write enable, irq_type_code
//
// One word at a time. Count and get nth read and check each stored entry in turn; a claim
// does the same, stops at the first overlap and else appends the range; release refills
// each removed entry from the last slot (one in the last slot is simply dropped). A claim
// or release without owner, or a claim on a full table, goes straight to the result. Each
// entry is read through the single read port of the entry memory, with registered data.
// Reset is synchronous; only entries below the count are read, so nothing is cleared.
// A result waits in the output register; the input is ready the cycle after it moves.
// Top level of the resource range claim table; depends on rrct_pkg, rrct_cmp
// and resource_range_claim_table_defines.svh.
`default_nettype none

module resource_range_claim_table #(
    parameter int unsigned TABLE_DEPTH = rrct_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned OWNER_COUNT = rrct_pkg::OWNER_COUNT_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration
    input  wire logic                             i_cfg_we,
    input  wire logic [rrct_pkg::TYPE_W-1:0]      i_cfg_wdata,
    // request stream
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // tdata: owner_id[4:0], res_type[7:5], res_start[71:8], res_size[135:72],
    //        nth_index[141:136], zero[143:142]
    input  wire logic [rrct_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: action[1:0], has_owner[2]
    input  wire logic [rrct_pkg::IN_TUSER_W-1:0]  i_s_axis_tuser,
    // result stream
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // tdata: match_count[6:0], out_type[9:7], out_start[73:10], out_size[137:74],
    //        zero[143:138]
    output logic [rrct_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // tuser: ok[0]
    output logic [rrct_pkg::OUT_TUSER_W-1:0]      o_m_axis_tuser
);
    import rrct_pkg::*;
    `include "resource_range_claim_table_defines.svh"

    localparam int unsigned IW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned OW = $clog2(OWNER_COUNT);
    localparam int unsigned KW = (CW > NTH_W) ? CW : NTH_W;
    localparam int unsigned OWNER_IDS = 2 ** OWNER_ID_W;

    // Registers
    t_state                r_state;
    t_state                n_state;
    logic [TYPE_W-1:0]     r_irq;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         r_hits;
    t_action               r_act;
    logic                  r_has_owner;
    logic [OW-1:0]         r_owner;
    t_range                r_req;
    logic [NTH_W-1:0]      r_nth;
    logic                  r_ok;
    logic                  r_found;
    t_range                r_got;
    t_range                r_rd_range;
    logic [OW-1:0]         r_rd_owner;
    logic                  r_out_valid;
    logic                  r_out_ok;
    logic [MC_W-1:0]       r_out_mc;
    logic [TYPE_W-1:0]     r_out_type;
    logic [VAL_W-1:0]      r_out_start;
    logic [VAL_W-1:0]      r_out_size;

    // Entry memory
    t_range                r_mem_range [TABLE_DEPTH];
    logic [OW-1:0]         r_mem_owner [TABLE_DEPTH];

    // Combinational signals
    logic                  w_accept;
    logic                  w_out_load;
    t_range                w_in_req;
    logic [OW-1:0]         w_owner_lut [OWNER_IDS];
    logic [CW-1:0]         w_last;
    logic                  w_full;
    logic                  w_more;
    t_cmp_res              w_cmp;
    logic                  w_hit;
    logic                  w_rel_last;
    logic                  w_rd_en;
    logic [IW-1:0]         w_rd_addr;
    logic                  w_wr_en;
    logic [IW-1:0]         w_wr_addr;
    t_range                w_wr_range;
    logic [OW-1:0]         w_wr_owner;
    logic                  w_res_ok;
    logic [MC_W-1:0]       w_res_mc;

    // Owner identifiers folded into the owner space.
    for (genvar g = 0; g < OWNER_IDS; g++) begin : g_owner_lut
        localparam int unsigned OwnerMod = g % OWNER_COUNT;
        assign w_owner_lut[g] = OW'(OwnerMod);
    end

    // Request unpacking; the end of the claimed range is formed once here.
    always_comb begin
        w_in_req.rtype = i_s_axis_tdata[7:5];
        w_in_req.start = i_s_axis_tdata[71:8];
        w_in_req.size  = i_s_axis_tdata[135:72];
        w_in_req.last  = i_s_axis_tdata[71:8] + i_s_axis_tdata[135:72] - VAL_W'(1);
    end

    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_out_load      = (r_state == ST_DONE) && (!r_out_valid || i_m_axis_tready);
    assign w_last          = r_count - CW'(1);
    assign w_full          = (r_count == CW'(TABLE_DEPTH));
    assign w_more          = (r_idx < r_count);
    assign w_hit           = !r_has_owner || w_cmp.owner_eq;
    assign w_rel_last      = (r_idx == w_last);

    // Shared compare unit, fed by the registered read data.
    rrct_cmp #(
        .OW(OW)
    ) u_cmp (
        .i_irq_type    (r_irq),
        .i_entry       (r_rd_range),
        .i_entry_owner (r_rd_owner),
        .i_req         (r_req),
        .i_req_owner   (r_owner),
        .o_res         (w_cmp)
    );

    // Next-state logic of the scan sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (t_action'(i_s_axis_tuser[1:0]))
                        ACT_CLAIM: begin
                            n_state = (i_s_axis_tuser[2] && !w_full) ? ST_READ : ST_DONE;
                        end
                        ACT_RELEASE: begin
                            n_state = i_s_axis_tuser[2] ? ST_READ : ST_DONE;
                        end
                        default: begin
                            n_state = ST_READ;
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (w_more) begin
                    n_state = ST_CHECK;
                end else if (r_act == ACT_CLAIM) begin
                    n_state = ST_APPEND;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_CHECK: begin
                case (r_act)
                    ACT_CLAIM: begin
                        n_state = w_cmp.overlap ? ST_DONE : ST_READ;
                    end
                    ACT_RELEASE: begin
                        n_state = (w_cmp.owner_eq && !w_rel_last) ? ST_MOVE : ST_READ;
                    end
                    default: begin
                        n_state = ST_READ;
                    end
                endcase
            end
            ST_MOVE: begin
                n_state = ST_READ;
            end
            ST_APPEND: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Memory port control per state.
    always_comb begin
        w_rd_en    = 1'b0;
        w_rd_addr  = r_idx[IW-1:0];
        w_wr_en    = 1'b0;
        w_wr_addr  = r_idx[IW-1:0];
        w_wr_range = r_rd_range;
        w_wr_owner = r_rd_owner;
        case (r_state)
            ST_READ: begin
                w_rd_en = w_more;
            end
            ST_CHECK: begin
                // A removed entry is refilled from the current last slot.
                w_rd_en   = (r_act == ACT_RELEASE) && w_cmp.owner_eq && !w_rel_last;
                w_rd_addr = w_last[IW-1:0];
            end
            ST_MOVE: begin
                w_wr_en = 1'b1;
            end
            ST_APPEND: begin
                w_wr_en    = 1'b1;
                w_wr_addr  = r_count[IW-1:0];
                w_wr_range = r_req;
                w_wr_owner = r_owner;
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
    end

    // Entry memory: one write port, one read port with registered data.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem_range[w_wr_addr] <= w_wr_range;
            r_mem_owner[w_wr_addr] <= w_wr_owner;
        end
        if (w_rd_en) begin
            r_rd_range <= r_mem_range[w_rd_addr];
            r_rd_owner <= r_mem_owner[w_rd_addr];
        end
    end

    // Result of the finished request.
    always_comb begin
        case (r_act)
            ACT_CLAIM: begin
                w_res_ok = r_ok;
                w_res_mc = MC_W'(r_count);
            end
            ACT_RELEASE: begin
                w_res_ok = r_has_owner;
                w_res_mc = MC_W'(r_count);
            end
            ACT_COUNT: begin
                w_res_ok = 1'b1;
                w_res_mc = MC_W'(r_hits);
            end
            default: begin
                w_res_ok = r_found;
                w_res_mc = MC_W'(r_hits);
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_irq       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_irq <= i_cfg_wdata;
            end
            if (r_state == ST_APPEND) begin
                r_count <= r_count + CW'(1);
            end else if ((r_state == ST_MOVE) ||
                         ((r_state == ST_CHECK) && (r_act == ACT_RELEASE) &&
                          w_cmp.owner_eq && w_rel_last)) begin
                r_count <= w_last;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request, scan and result payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act       <= t_action'(i_s_axis_tuser[1:0]);
            r_has_owner <= i_s_axis_tuser[2];
            r_owner     <= w_owner_lut[i_s_axis_tdata[4:0]];
            r_req       <= w_in_req;
            r_nth       <= i_s_axis_tdata[141:136];
            r_idx       <= '0;
            r_hits      <= '0;
            r_ok        <= 1'b0;
            r_found     <= 1'b0;
            r_got       <= '0;
        end
        if (r_state == ST_APPEND) begin
            r_ok <= 1'b1;
        end
        if (r_state == ST_CHECK) begin
            case (r_act)
                ACT_CLAIM: begin
                    r_idx <= r_idx + CW'(1);
                end
                ACT_RELEASE: begin
                    // A matching slot is tested again after it is refilled.
                    if (!w_cmp.owner_eq) begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                default: begin
                    if (w_hit) begin
                        if ((r_act == ACT_GET) && !r_found &&
                            (KW'(r_nth) == KW'(r_hits))) begin
                            r_found <= 1'b1;
                            r_got   <= r_rd_range;
                        end
                        r_hits <= r_hits + CW'(1);
                    end
                    r_idx <= r_idx + CW'(1);
                end
            endcase
        end
        if (w_out_load) begin
            r_out_ok    <= w_res_ok;
            r_out_mc    <= w_res_mc;
            r_out_type  <= r_got.rtype;
            r_out_start <= r_got.start;
            r_out_size  <= r_got.size;
        end
    end

    // Result word packing.
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_ok;
    assign o_m_axis_tdata  = {6'd0, r_out_size, r_out_start, r_out_type, r_out_mc};

    // Assertions
    `RRCT_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(TABLE_DEPTH),
                     "entry count above table depth")
    `RRCT_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, w_accept, r_state != ST_IDLE,
                     "sequencer idle after accepting a word")
    `RRCT_ASSERT_NXT(a_append_grow, i_clk, i_rst_n, r_state == ST_APPEND,
                     r_count == $past(r_count) + CW'(1), "append did not add one entry")
    `RRCT_ASSERT_NXT(a_move_shrink, i_clk, i_rst_n, r_state == ST_MOVE,
                     r_count == $past(r_count) - CW'(1), "refill did not remove one entry")

endmodule

`default_nettype wire
